// ===== hdl/dnsd_pkg.sv =====
// Shared types and constants of the DNS name decompressor.
`timescale 1ns / 1ps
package dnsd_pkg;

    localparam int PACKET_BYTES_DEF = 4096;
    localparam int MAX_HOPS_DEF     = 16;

    // Offsets hold a 14-bit pointer target and a length up to 16384.
    localparam int POS_W       = 15;
    localparam int TEXT_WORDS  = 32;
    localparam int TEXT_IDX_W  = 5;
    localparam int TEXT_CNT_W  = 6;
    localparam int ROOM_W      = 9;
    localparam logic [ROOM_W-1:0] ROOM_MAX = 9'd256;

    localparam logic [1:0] LABEL_NORMAL  = 2'b00;
    localparam logic [1:0] LABEL_POINTER = 2'b11;
    localparam logic [7:0] DOT_CHAR      = 8'h2E;
    localparam logic [3:0] FULL_CHUNK    = 4'd8;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OUT_OF_BOUNDS = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_BAD_LABEL = 3'd3,
        ST_HOP_LIMIT = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_LABEL,
        S_PTR,
        S_COPY,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_FINAL,
        S_ERROR
    } t_state;

    typedef struct packed {
        logic        opcode;
        logic [11:0] byte_address;
        logic [7:0]  byte_value;
        logic [12:0] packet_length;
        logic [11:0] start_offset;
    } t_dec_req;

    typedef struct packed {
        logic [63:0] name_chunk;
        logic [3:0]  chunk_bytes;
        logic [2:0]  status;
        logic [12:0] consumed_length;
        logic        last_result;
    } t_dec_res;

endpackage

// ===== hdl/dnsd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module dnsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/dns_name_decompressor_core.sv =====
// Top level of the DNS name decompressor: packet store, label walker, chunk output.
`timescale 1ns / 1ps
// Usage. A command beat is taken on a rising edge with start high and busy low.
// A load command writes one byte into the packet store; it gives no result and
// busy stays low. A decode command walks the name at start_offset: each label
// length byte is read, then decoded, each pointer also has its second byte
// read, and the label text bytes come from a pipelined read of the packet
// store, which is drained at the end of the label. The text is gathered into
// 64-bit words held in a 32-word text RAM, so nothing is shown until the walk
// finishes. Then every full 8-byte chunk leaves as a result beat (text RAM
// read, then output), followed by a final beat with the remaining bytes, the
// status and the consumed length. A failing decode gives one final beat
// carrying only the error status. Results appear on o_res for exactly one
// cycle with o_res_strobe high; the receiver cannot stall them. The
// name_capacity register is written through i_cfg_valid/o_cfg_ready, which is
// always ready; it must be written only while busy is low. Reset clears the
// control state and sets the capacity to 256; the packet store is not cleared
// and must be loaded before a decode reads it. Both RAMs have registered reads.
module dns_name_decompressor_core
    import dnsd_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int MAX_HOPS     = MAX_HOPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_dec_req    i_req,
    output logic        o_res_strobe,
    output t_dec_res    o_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data
);

    localparam int AW = $clog2(PACKET_BYTES);
    localparam int HW = $clog2(MAX_HOPS + 1);

    t_state                r_state, n_state;
    logic [POS_W-1:0]      r_size, n_size;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [POS_W-1:0]      r_consumed, n_consumed;
    logic [ROOM_W-1:0]     r_room, n_room;
    logic [ROOM_W-1:0]     r_cap;
    logic [HW-1:0]         r_hops, n_hops;
    logic                  r_comp, n_comp;
    logic                  r_first, n_first;
    t_status               r_status, n_status;
    logic [63:0]           r_chunk, n_chunk;
    logic [2:0]            r_cb, n_cb;
    logic [TEXT_CNT_W-1:0] r_wi, n_wi;
    logic [TEXT_CNT_W-1:0] r_ei, n_ei;
    logic [5:0]            r_left, n_left;
    logic                  r_rvld, n_rvld;
    logic [7:0]            r_label, n_label;
    t_dec_res              r_out, n_out;
    logic                  r_out_vld, n_out_vld;

    logic                  accept;
    logic                  pk_we;
    logic [AW-1:0]         pk_raddr;
    logic [7:0]            pk_rdata;
    logic                  txt_we;
    logic [63:0]           txt_wdata;
    logic [TEXT_IDX_W-1:0] txt_raddr;
    logic [63:0]           txt_rdata;
    logic                  app_en;
    logic [7:0]            app_byte;
    logic [63:0]           app_word;
    logic [POS_W-1:0]      len_ext;
    logic [POS_W-1:0]      pos_inc;
    logic [POS_W:0]        label_end;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign len_ext     = POS_W'(i_req.packet_length);
    assign pos_inc     = r_pos + POS_W'(1);
    assign label_end   = {1'b0, pos_inc} + (POS_W + 1)'(pk_rdata[5:0]);

    // Loads write the store only for addresses inside the packet store.
    assign pk_we = accept && (i_req.opcode == OP_LOAD)
                   && (POS_W'(i_req.byte_address) < POS_W'(PACKET_BYTES));
    // A pointer's second byte is fetched while its first byte is decoded.
    assign pk_raddr = (r_state == S_LABEL) ? AW'(pos_inc) : AW'(r_pos);
    assign txt_raddr = r_ei[TEXT_IDX_W-1:0];

    dnsd_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_packet_ram (
        .i_clk   (i_clk),
        .i_we    (pk_we),
        .i_waddr (AW'(i_req.byte_address)),
        .i_wdata (i_req.byte_value),
        .i_raddr (pk_raddr),
        .o_rdata (pk_rdata)
    );

    dnsd_ram #(.WIDTH(64), .DEPTH(TEXT_WORDS)) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (txt_we),
        .i_waddr (r_wi[TEXT_IDX_W-1:0]),
        .i_wdata (txt_wdata),
        .i_raddr (txt_raddr),
        .o_rdata (txt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= ROOM_MAX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_rvld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_rvld    <= n_rvld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size     <= n_size;
        r_pos      <= n_pos;
        r_consumed <= n_consumed;
        r_room     <= n_room;
        r_hops     <= n_hops;
        r_comp     <= n_comp;
        r_first    <= n_first;
        r_status   <= n_status;
        r_chunk    <= n_chunk;
        r_cb       <= n_cb;
        r_wi       <= n_wi;
        r_ei       <= n_ei;
        r_left     <= n_left;
        r_label    <= n_label;
        r_out      <= n_out;
    end

    // Appending one text byte; a completed word goes to the text RAM.
    always_comb begin
        app_word = r_chunk;
        app_word[r_cb*8 +: 8] = app_byte;
    end

    always_comb begin
        n_state    = r_state;
        n_size     = r_size;
        n_pos      = r_pos;
        n_consumed = r_consumed;
        n_room     = r_room;
        n_hops     = r_hops;
        n_comp     = r_comp;
        n_first    = r_first;
        n_status   = r_status;
        n_left     = r_left;
        n_rvld     = 1'b0;
        n_label    = r_label;
        n_ei       = r_ei;
        n_out      = r_out;
        n_out_vld  = 1'b0;
        app_en     = 1'b0;
        app_byte   = DOT_CHAR;

        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_req.opcode == OP_DECODE)) begin
                    n_size     = (len_ext > POS_W'(PACKET_BYTES))
                                 ? POS_W'(PACKET_BYTES) : len_ext;
                    n_pos      = POS_W'(i_req.start_offset);
                    n_room     = (r_cap > ROOM_MAX) ? ROOM_MAX : r_cap;
                    n_consumed = '0;
                    n_hops     = '0;
                    n_comp     = 1'b0;
                    n_first    = 1'b1;
                    n_ei       = '0;
                    n_state    = S_FETCH;
                end
            end
            S_FETCH: begin
                if (r_pos >= r_size) begin
                    n_status = ST_OUT_OF_BOUNDS;
                    n_state  = S_ERROR;
                end else begin
                    n_state = S_LABEL;
                end
            end
            S_LABEL: begin
                if (pk_rdata == 8'd0) begin
                    if (!r_comp) begin
                        n_consumed = r_consumed + POS_W'(1);
                    end
                    if (r_room == '0) begin
                        n_status = ST_TOO_LONG;
                        n_state  = S_ERROR;
                    end else begin
                        n_state = S_EMIT_RD;
                    end
                end else if (pk_rdata[7:6] == LABEL_NORMAL) begin
                    if (label_end > {1'b0, r_size}) begin
                        n_status = ST_OUT_OF_BOUNDS;
                        n_state  = S_ERROR;
                    end else if (ROOM_W'(pk_rdata[5:0]) + ROOM_W'(1) > r_room) begin
                        n_status = ST_TOO_LONG;
                        n_state  = S_ERROR;
                    end else begin
                        app_en  = !r_first;
                        n_room  = r_room - ROOM_W'(pk_rdata[5:0])
                                  - (r_first ? ROOM_W'(0) : ROOM_W'(1));
                        n_first = 1'b0;
                        n_pos   = pos_inc;
                        n_left  = pk_rdata[5:0];
                        if (!r_comp) begin
                            n_consumed = r_consumed + POS_W'(1) + POS_W'(pk_rdata[5:0]);
                        end
                        n_state = S_COPY;
                    end
                end else if (pk_rdata[7:6] == LABEL_POINTER) begin
                    if (pos_inc >= r_size) begin
                        n_status = ST_OUT_OF_BOUNDS;
                        n_state  = S_ERROR;
                    end else if (r_hops >= HW'(MAX_HOPS)) begin
                        n_status = ST_HOP_LIMIT;
                        n_state  = S_ERROR;
                    end else begin
                        n_hops  = r_hops + HW'(1);
                        n_label = pk_rdata;
                        n_state = S_PTR;
                    end
                end else begin
                    n_status = ST_BAD_LABEL;
                    n_state  = S_ERROR;
                end
            end
            S_PTR: begin
                n_pos = POS_W'({r_label[5:0], pk_rdata});
                if (!r_comp) begin
                    n_consumed = r_consumed + POS_W'(2);
                end
                n_comp  = 1'b1;
                n_state = S_FETCH;
            end
            S_COPY: begin
                // Reads are issued every cycle while bytes remain; each byte lands in the next cycle.
                if (r_left != '0) begin
                    n_pos  = pos_inc;
                    n_left = r_left - 6'd1;
                    n_rvld = 1'b1;
                end
                if (r_rvld) begin
                    app_en   = 1'b1;
                    app_byte = pk_rdata;
                end
                if ((r_left == '0) && !r_rvld) begin
                    n_state = S_FETCH;
                end
            end
            S_EMIT_RD: begin
                n_state = (r_ei < r_wi) ? S_EMIT_OUT : S_FINAL;
            end
            S_EMIT_OUT: begin
                n_out.name_chunk      = txt_rdata;
                n_out.chunk_bytes     = FULL_CHUNK;
                n_out.status          = ST_OK;
                n_out.consumed_length = '0;
                n_out.last_result     = 1'b0;
                n_out_vld             = 1'b1;
                n_ei                  = r_ei + TEXT_CNT_W'(1);
                n_state               = S_EMIT_RD;
            end
            S_FINAL: begin
                n_out.name_chunk      = r_chunk;
                n_out.chunk_bytes     = {1'b0, r_cb};
                n_out.status          = ST_OK;
                n_out.consumed_length = r_consumed[12:0];
                n_out.last_result     = 1'b1;
                n_out_vld             = 1'b1;
                n_state               = S_IDLE;
            end
            S_ERROR: begin
                n_out.name_chunk      = '0;
                n_out.chunk_bytes     = '0;
                n_out.status          = r_status;
                n_out.consumed_length = '0;
                n_out.last_result     = 1'b1;
                n_out_vld             = 1'b1;
                n_state               = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Text assembly: bytes fill r_chunk low byte first, and every eighth byte
    // writes the finished word to the text RAM and starts a cleared word.
    always_comb begin
        n_chunk   = r_chunk;
        n_cb      = r_cb;
        n_wi      = r_wi;
        txt_we    = 1'b0;
        txt_wdata = app_word;
        if (accept) begin
            n_chunk = '0;
            n_cb    = '0;
            n_wi    = '0;
        end else if (app_en) begin
            n_cb = r_cb + 3'd1;
            if (r_cb == 3'd7) begin
                txt_we  = 1'b1;
                n_chunk = '0;
                n_wi    = r_wi + TEXT_CNT_W'(1);
            end else begin
                n_chunk = app_word;
            end
        end
    end

    assign o_res_strobe = r_out_vld;
    assign o_res        = r_out;

`ifndef SYNTH
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(busy))
        else $error("result beat without a decode in progress");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.last_result) |=> !o_res_strobe)
        else $error("result beat after the final beat");

    a_error_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && (o_res.status != ST_OK))
            |-> (o_res.last_result && (o_res.chunk_bytes == 4'd0)))
        else $error("error beat carries name text");

    a_room_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_room <= ROOM_MAX))
        else $error("name room above capacity limit");

    a_text_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        txt_we |-> (r_wi < TEXT_CNT_W'(TEXT_WORDS)))
        else $error("text RAM write past its last word");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the DNS name decompressor core.
`timescale 1ns / 1ps
module tb;
    import dnsd_pkg::*;

    localparam int PKT_BYTES   = 4096;
    localparam int HOP_LIMIT   = 16;
    localparam int STALL_LIMIT = 20000;
    localparam int TOTAL_ITEMS = 370;

    // Expected decode results, checked in order against the result beats.
    class name_scoreboard;
        t_dec_res pending[$];
        int       errors;
        int       checked;
        int       decodes;

        // Notes one accepted decode and queues the result beats it must give.
        function void note_decode(t_dec_res beats[$]);
            decodes++;
            foreach (beats[k]) pending.push_back(beats[k]);
        endfunction

        task check_beat(t_dec_res got);
            t_dec_res want;
            checked++;
            if (pending.size() == 0) begin
                report("result beat with no decode waiting", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.name_chunk !== want.name_chunk)
                report("name_chunk", got.name_chunk, want.name_chunk);
            if (got.chunk_bytes !== want.chunk_bytes)
                report("chunk_bytes", 64'(got.chunk_bytes), 64'(want.chunk_bytes));
            if (got.status !== want.status)
                report("status", 64'(got.status), 64'(want.status));
            if (got.consumed_length !== want.consumed_length)
                report("consumed_length", 64'(got.consumed_length),
                       64'(want.consumed_length));
            if (got.last_result !== want.last_result)
                report("last_result", 64'(got.last_result), 64'(want.last_result));
        endtask

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch on %s: got %h, want %h at %0t", what, got, want, $realtime);
        endtask
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_dec_req i_req;
    logic     o_res_strobe;
    t_dec_res o_res;
    logic     i_cfg_valid;
    logic     o_cfg_ready;
    logic [8:0] i_cfg_data;

    dns_name_decompressor_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_res_strobe(o_res_strobe), .o_res(o_res), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Mirror of the packet store and the capacity register.
    logic [7:0]  store_copy [PKT_BYTES];
    bit          written [PKT_BYTES];
    logic [8:0]  capacity;
    name_scoreboard sb;
    int          idle_cycles;
    int          loads_sent;
    int          items_sent;

    always @(posedge i_clk) begin
        if (o_res_strobe) sb.check_beat(o_res);
        if ((start && !busy) || o_res_strobe || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: %0d cycles without a beat", idle_cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Walks the name as the block does and builds the result beats. The miss
    // flag is set when the walk would read a store entry never loaded.
    function automatic void decode_name(input logic [12:0] plen, input logic [11:0] offs,
                                        output t_dec_res beats[$], output bit miss);
        logic [7:0] text[$];
        int size, pos, room, consumed, hops, n, full, cnt;
        t_status st;
        bit compressed, first, done;
        t_dec_res r;
        size = (plen > PKT_BYTES) ? PKT_BYTES : plen;
        pos = offs;
        room = (capacity > 256) ? 256 : capacity;
        consumed = 0; hops = 0; st = ST_OK;
        compressed = 0; first = 1; done = 0; miss = 0;
        beats = {};
        while (!done && st == ST_OK && !miss) begin
            if (pos + 1 > size) begin
                st = ST_OUT_OF_BOUNDS;
            end else if (!written[pos]) begin
                miss = 1;
            end else begin
                n = store_copy[pos];
                if (n == 0) begin
                    pos++;
                    if (!compressed) consumed++;
                    if (room < 1) st = ST_TOO_LONG;
                    done = 1;
                end else if (n <= 63) begin
                    pos++;
                    if (!compressed) consumed++;
                    if (pos + n > size) st = ST_OUT_OF_BOUNDS;
                    else if (n + 1 > room) st = ST_TOO_LONG;
                    else begin
                        for (int i = 0; i < n; i++) if (!written[pos + i]) miss = 1;
                        if (!miss) begin
                            if (!first) begin
                                text.push_back(DOT_CHAR);
                                room--;
                            end
                            first = 0;
                            for (int i = 0; i < n; i++) text.push_back(store_copy[pos + i]);
                            room -= n;
                            pos += n;
                            if (!compressed) consumed += n;
                        end
                    end
                end else if (n[7:6] == LABEL_POINTER) begin
                    if (pos + 2 > size) st = ST_OUT_OF_BOUNDS;
                    else begin
                        hops++;
                        if (hops > HOP_LIMIT) st = ST_HOP_LIMIT;
                        else if (!written[pos + 1]) miss = 1;
                        else begin
                            pos = (n[5:0] << 8) | store_copy[pos + 1];
                            if (!compressed) consumed += 2;
                            compressed = 1;
                        end
                    end
                end else begin
                    st = ST_BAD_LABEL;
                end
            end
        end
        if (miss) return;
        if (st != ST_OK) begin
            r = '0;
            r.status = st;
            r.last_result = 1'b1;
            beats.push_back(r);
            return;
        end
        full = text.size() / 8;
        for (int k = 0; k <= full; k++) begin
            r = '0;
            cnt = (k < full) ? 8 : text.size() - k * 8;
            for (int i = 0; i < cnt; i++) r.name_chunk[8*i +: 8] = text[k*8 + i];
            r.chunk_bytes = 4'(cnt);
            if (k == full) begin
                r.consumed_length = 13'(consumed);
                r.last_result = 1'b1;
            end
            beats.push_back(r);
        end
    endfunction

    // Starts at a falling edge and returns at the falling edge after the
    // accepting edge with start still high; the next beat or drain lowers it.
    task automatic send_beat(input t_dec_req req);
        t_dec_res beats[$];
        bit miss;
        int gap;
        gap = $urandom_range(0, 18);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req <= req;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // The beat is taken at this edge; predict against the state it saw.
        items_sent++;
        if (req.opcode == OP_LOAD) begin
            store_copy[req.byte_address] = req.byte_value;
            written[req.byte_address] = 1'b1;
            loads_sent++;
        end else begin
            decode_name(req.packet_length, req.start_offset, beats, miss);
            sb.note_decode(beats);
        end
        @(negedge i_clk);
    endtask

    task automatic load_byte(input int addr, input logic [7:0] val);
        t_dec_req req;
        req = '0;
        req.opcode = OP_LOAD;
        req.byte_address = 12'(addr);
        req.byte_value = val;
        send_beat(req);
    endtask

    // Decodes only names whose walk stays on loaded store entries.
    task automatic decode(input int plen, input int offs);
        t_dec_req req;
        t_dec_res beats[$];
        bit miss;
        req = '0;
        req.byte_address = 12'($urandom());
        req.byte_value = 8'($urandom());
        req.opcode = OP_DECODE;
        req.packet_length = 13'(plen);
        req.start_offset = 12'(offs);
        decode_name(req.packet_length, req.start_offset, beats, miss);
        if (!miss) send_beat(req);
    endtask

    // Waits for every expected beat, plus slack for a walk still running.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic set_capacity(input logic [8:0] cap);
        drain();
        i_cfg_data <= cap;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        capacity = cap;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Writes a label of random bytes at addr; returns the next free address.
    task automatic put_label(input int addr, input int len, output int nxt);
        load_byte(addr, 8'(len));
        for (int i = 0; i < len; i++) load_byte(addr + 1 + i, 8'($urandom()));
        nxt = addr + 1 + len;
    endtask

    // Builds a name, possibly malformed, in a small region and decodes it.
    task automatic random_name(input int base);
        int a, nl, pick, len, tgt;
        a = base;
        nl = $urandom_range(0, 3);
        for (int l = 0; l < nl; l++) put_label(a, $urandom_range(1, 12), a);
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            load_byte(a, 8'h00);
            len = a + 1;
        end else if (pick < 7) begin
            // Point back at the previous region's name, or into the first name.
            tgt = (base > 200) ? base - 60 : $urandom_range(0, 65);
            load_byte(a, 8'hC0 | 8'(tgt >> 8));
            load_byte(a + 1, 8'(tgt));
            len = a + 2;
        end else begin
            load_byte(a, 8'($urandom()));
            len = a + 1;
        end
        if ($urandom_range(0, 4) == 0) len = $urandom_range(0, len + 2);
        decode(len, base);
    endtask

    int a;
    t_dec_req noise;
    initial begin
        sb = new();
        start = 1'b0;
        i_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        capacity = 9'd256;
        idle_cycles = 0;
        loads_sent = 0;
        items_sent = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: root name, a plain name, pointers, loop, bad types, bounds.
        load_byte(0, 8'h00);
        decode(1, 0);
        decode(0, 0);
        decode(8191, 0);
        put_label(1, 63, a);
        load_byte(a, 8'h00);
        decode(a + 1, 1);
        decode(a, 1);
        load_byte(100, 8'hC0);
        load_byte(101, 8'h01);
        decode(102, 100);
        load_byte(110, 8'hC0);
        load_byte(111, 8'd110);
        decode(112, 110);
        load_byte(120, 8'h40);
        decode(121, 120);
        load_byte(121, 8'h80);
        decode(122, 121);
        load_byte(122, 8'hFF);
        load_byte(123, 8'hFF);
        decode(124, 122);
        load_byte(4095, 8'hAA);
        decode(4096, 4095);

        // Pause the sender until the block has delivered everything.
        drain();
        set_capacity(9'd0);
        decode(1, 0);
        set_capacity(9'd64);
        decode(a + 1, 1);
        set_capacity(9'd65);
        decode(a + 1, 1);
        set_capacity(9'd511);
        decode(a + 1, 1);

        for (int i = 0; items_sent < TOTAL_ITEMS; i++) begin
            if (i % 12 == 0) begin
                case ($urandom_range(0, 3))
                    0: set_capacity(9'd1);
                    1: set_capacity(9'($urandom_range(2, 40)));
                    2: set_capacity(9'd256);
                    default: set_capacity(9'($urandom()));
                endcase
            end
            if ($urandom_range(0, 5) == 0) begin
                // Noise: stray loads anywhere and decodes of written bytes only.
                noise = '0;
                noise.opcode = OP_LOAD;
                noise.byte_address = 12'($urandom());
                noise.byte_value = 8'($urandom());
                send_beat(noise);
                if (written[noise.byte_address])
                    decode(int'($urandom_range(0, 8191)), int'(noise.byte_address));
            end else begin
                random_name(200 + 60 * (i % 40));
            end
        end
        drain();
        $display("covered %0d decodes and %0d loads, %0d result beats checked",
                 sb.decodes, loads_sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
